[src/gfb_pkg.sv]
`timescale 1ns / 1ps
package gfb_pkg;
  localparam int AspectWidth = 21;
  localparam int RadiusWidth = 17;
  localparam int DivisionWidth = 22;
  localparam int AspectFloor = 7;
endpackage

[src/graticule_fit_bisection_top.sv]
`timescale 1ns / 1ps
// Graticule fit by bisection on a rounded-rectangle face.
// Input channel: in_valid/in_ready carry face_aspect and corner_radius
// (unsigned Q.FRAC_BITS). Output channel: out_valid/out_ready carry division.
// One request in gives exactly one result out, in order.
// A prep stage clamps the inputs, then a row of HALVINGS identical cells each
// does one halving step and passes lo/hi on to the next.
// Throughput: one request per cycle unless the receiver stalls; every stage holds one request.
// The last cell's register is the output register.
// When the receiver stalls the whole row holds; in_ready is low only while a
// result waits and out_ready is low.
// Reset (rst, synchronous) clears all stage valid bits; no result is pending.
module graticule_fit_bisection_top #(
  parameter int HALVINGS = 30,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gfb_pkg::AspectWidth-1:0]   face_aspect,
  input  logic [gfb_pkg::RadiusWidth-1:0]   corner_radius,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gfb_pkg::DivisionWidth-1:0] division
);
  import gfb_pkg::*;
  localparam int RW = FRAC_BITS + 1;
  localparam int MW = ((AspectWidth > RW) ? AspectWidth : RW) + 1;

  logic adv;
  logic [HALVINGS:0] vld;
  logic [MW-1:0] lo_s [0:HALVINGS];
  logic [MW-1:0] hi_s [0:HALVINGS];
  logic [AspectWidth-1:0] ax_s [0:HALVINGS];
  logic [RW-1:0] rad_s [0:HALVINGS];
  logic [MW:0] fin;

  assign adv = !vld[HALVINGS] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[HALVINGS];
  assign fin = {1'b0, lo_s[HALVINGS]} + {1'b0, hi_s[HALVINGS]};
  assign division = fin[DivisionWidth:1];
  assign lo_s[0] = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[HALVINGS-1:0], in_valid};
    end
  end

  gfb_prep #(.FRAC_BITS(FRAC_BITS), .RW(RW), .MW(MW)) u_prep (
    .clk(clk), .en(adv), .face_aspect(face_aspect), .corner_radius(corner_radius),
    .ax(ax_s[0]), .rad(rad_s[0]), .hi(hi_s[0])
  );

  for (genvar g = 0; g < HALVINGS; g++) begin : g_cell
    gfb_cell #(.FRAC_BITS(FRAC_BITS), .RW(RW), .MW(MW)) u_cell (
      .clk(clk), .en(adv),
      .prev_lo(lo_s[g]), .prev_hi(hi_s[g]), .prev_ax(ax_s[g]), .prev_rad(rad_s[g]),
      .lo(lo_s[g+1]), .hi(hi_s[g+1]), .ax(ax_s[g+1]), .rad(rad_s[g+1])
    );
  end

  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid bits not cleared by reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved during stall");
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lo_s[HALVINGS] <= hi_s[HALVINGS])
    else $error("bisection bracket inverted");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
endmodule

[src/gfb_prep.sv]
`timescale 1ns / 1ps
module gfb_prep #(
  parameter int FRAC_BITS = 16,
  parameter int RW = 17,
  parameter int MW = 22
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [gfb_pkg::AspectWidth-1:0]    face_aspect,
  input  logic [gfb_pkg::RadiusWidth-1:0]    corner_radius,
  output logic [gfb_pkg::AspectWidth-1:0]    ax,
  output logic [RW-1:0]                      rad,
  output logic [MW-1:0]                      hi
);
  import gfb_pkg::*;
  localparam int XW = (AspectWidth > RW) ? AspectWidth : RW;
  localparam int CW = (RadiusWidth > RW) ? RadiusWidth : RW;
  localparam logic [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

  logic [AspectWidth-1:0] axf;
  logic [XW-1:0] axe;
  logic [CW-1:0] cre;
  logic [RW-1:0] crc;
  logic [RW-1:0] amin;
  logic [2*RW-1:0] prod;
  logic [XW-1:0] amax;

  always_comb begin
    axf = (face_aspect < AspectWidth'(AspectFloor)) ? AspectWidth'(AspectFloor) : face_aspect;
    axe = XW'(axf);
    cre = CW'(corner_radius);
    crc = (cre > ONE_C) ? RW'(ONE_C) : RW'(cre);
    amin = (axe < ONE_X) ? RW'(axe) : RW'(ONE_X);
    prod = (2*RW)'(crc) * (2*RW)'(amin);
    amax = (axe > ONE_X) ? axe : ONE_X;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= axf;
      rad <= RW'(prod >> FRAC_BITS);
      hi <= MW'({amax, 1'b0});
    end
  end
endmodule

[src/gfb_cell.sv]
`timescale 1ns / 1ps
module gfb_cell #(
  parameter int FRAC_BITS = 16,
  parameter int RW = 17,
  parameter int MW = 22
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [MW-1:0]                   prev_lo,
  input  logic [MW-1:0]                   prev_hi,
  input  logic [gfb_pkg::AspectWidth-1:0] prev_ax,
  input  logic [RW-1:0]                   prev_rad,
  output logic [MW-1:0]                   lo,
  output logic [MW-1:0]                   hi,
  output logic [gfb_pkg::AspectWidth-1:0] ax,
  output logic [RW-1:0]                   rad
);
  import gfb_pkg::*;
  localparam int QW = MW + 4;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  logic [MW:0] sum;
  logic [MW-1:0] mid;
  logic [MW+2:0] m5;
  logic signed [QW-1:0] qx, qy, rq, qm;
  logic px, py, big;
  logic [RW-1:0] mx, my;
  logic [2*RW:0] dist2, rad2;
  logic fits;

  always_comb begin
    sum = {1'b0, prev_lo} + {1'b0, prev_hi};
    mid = sum[MW:1];
    m5 = (MW+3)'({mid, 2'b00}) + (MW+3)'(mid);
    rq = $signed(QW'(prev_rad));
    qx = $signed({1'b0, m5}) - $signed(QW'(prev_ax)) + rq;
    qy = $signed(QW'({mid, 2'b00})) - $signed(ONE_Q) + rq;
    px = qx > 0;
    py = qy > 0;
    big = (px && qx >= rq) || (py && qy >= rq);
    mx = px ? qx[RW-1:0] : '0;
    my = py ? qy[RW-1:0] : '0;
    dist2 = (2*RW+1)'(mx) * (2*RW+1)'(mx) + (2*RW+1)'(my) * (2*RW+1)'(my);
    rad2 = (2*RW+1)'(prev_rad) * (2*RW+1)'(prev_rad);
    qm = (qx > qy) ? qx : qy;
    if (px || py) begin
      fits = !big && (dist2 < rad2);
    end else begin
      fits = qm < rq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo <= fits ? mid : prev_lo;
      hi <= fits ? prev_hi : mid;
      ax <= prev_ax;
      rad <= prev_rad;
    end
  end
endmodule
